// ===== rtl/slc_pkg.sv =====
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types and constants for the set-associative LRU cache tag model.
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_WIDTH_DEF   = 64;

  localparam int ADDR_FIELD_W = 64;
  localparam int STAMP_W      = 64;
  localparam int CNT_W        = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 5;

  // Access kinds; the fourth code is ignored by the block.
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_STORE  = 2'd1;
  localparam logic [1:0] KIND_MODIFY = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  localparam logic [2:0] SET_BITS_RST   = 3'd4;
  localparam logic [4:0] BLOCK_BITS_RST = 5'd4;
  localparam logic [3:0] WAYS_RST       = 4'd1;

  typedef struct packed {
    logic [1:0]              kind;
    logic [ADDR_FIELD_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       hits_added;
    logic             missed;
    logic             evicted;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } out_item_t;

  typedef struct packed {
    logic [2:0] set_bits;
    logic [4:0] block_bits;
    logic [3:0] ways_in_use;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctl_cmd_t;

endpackage

// ===== rtl/slc_ctrl.sv =====
// ----------------------------------------------------------------------------
// slc_ctrl
// Sequencer: captures an item and reads its set, then commits the update.
// ----------------------------------------------------------------------------
module slc_ctrl
  import slc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output ctl_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    busy_nxt  = busy_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LOOK;
          busy_nxt  = 1'b1;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_IDLE;
        busy_nxt  = 1'b0;
      end
      default: begin
        state_nxt = ST_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy        = busy_r;
  assign cmd.capture = start && (state_r == ST_IDLE);
  assign cmd.commit  = (state_r == ST_LOOK);

endmodule

// ===== rtl/slc_datapath.sv =====
// ----------------------------------------------------------------------------
// slc_datapath
// Set row memory, tag compare, LRU victim choice, write-back and counters.
// ----------------------------------------------------------------------------
module slc_datapath
  import slc_pkg::*;
#(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctl_cmd_t  cmd,
  input  cfg_t      cfg,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int SETS   = 1 << MAX_SET_BITS;
  localparam int SET_IW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_IW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  typedef struct packed {
    logic [MAX_WAYS-1:0]                 valid;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag;
    logic [MAX_WAYS-1:0][STAMP_W-1:0]    stamp;
  } row_t;

  // One row per set holds every way, so a single read serves the lookup.
  row_t            mem [SETS];
  logic [SETS-1:0] row_init_r;

  row_t                  rd_row_r;
  logic                  row_ok_r;
  logic [1:0]            kind_r;
  logic [ADDR_WIDTH-1:0] tag_r;
  logic [SET_IW-1:0]     set_r;

  logic [STAMP_W-1:0] stamp_r;
  logic [CNT_W-1:0]   hits_r, misses_r, evicts_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  // Address decode at capture.
  logic [2:0]            sb;
  logic [5:0]            shift;
  logic [ADDR_WIDTH-1:0] addr_n, tag_c, above;
  logic [SET_IW-1:0]     set_mask, set_idx;

  always_comb begin
    sb     = (int'(cfg.set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : cfg.set_bits;
    shift  = 6'(sb) + 6'(cfg.block_bits);
    addr_n = in_data.address[ADDR_WIDTH-1:0];
    tag_c  = addr_n >> shift;
    above  = addr_n >> cfg.block_bits;
    for (int i = 0; i < SET_IW; i++) begin
      set_mask[i] = (i < int'(sb));
    end
    set_idx = above[SET_IW-1:0] & set_mask;
  end

  // Lookup on the registered row.
  logic [MAX_WAYS-1:0]               active, row_v, hit_vec, free_vec, vict_vec;
  logic [MAX_WAYS-1:0][MAX_WAYS-1:0] lt;
  logic                              hit, full, is_mod, kind_ok, wr_en;
  logic [WAY_IW-1:0]                 hit_way, free_way, vict_way, sel_way;
  logic [STAMP_W-1:0]                line_stamp, stamp_nxt;
  logic [1:0]                        hits_add;
  logic                              missed, evicted;
  row_t                              wr_row;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      active[w] = (w == 0) || (w < int'(cfg.ways_in_use));
    end
    row_v = row_ok_r ? rd_row_r.valid : '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      hit_vec[w]  = active[w] && row_v[w] && (rd_row_r.tag[w] == tag_r);
      free_vec[w] = active[w] && !row_v[w];
    end
    hit  = |hit_vec;
    full = ~|free_vec;

    // Pairwise stamp compares; the oldest way is the lowest one whose stamp
    // is strictly below every lower active way and not above any higher one.
    for (int i = 0; i < MAX_WAYS; i++) begin
      for (int j = 0; j < MAX_WAYS; j++) begin
        lt[i][j] = rd_row_r.stamp[i] < rd_row_r.stamp[j];
      end
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      vict_vec[i] = active[i];
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (active[j] && (j < i) && !lt[i][j]) vict_vec[i] = 1'b0;
        if (active[j] && (j > i) && lt[j][i])  vict_vec[i] = 1'b0;
      end
    end

    hit_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = WAY_IW'(w);
    end
    vict_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (vict_vec[w]) vict_way = WAY_IW'(w);
    end
    free_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (free_vec[w]) free_way = WAY_IW'(w);
    end
    sel_way = hit ? hit_way : (full ? vict_way : free_way);

    case (kind_r) inside
      KIND_LOAD, KIND_STORE: begin
        kind_ok = 1'b1;
        is_mod  = 1'b0;
      end
      KIND_MODIFY: begin
        kind_ok = 1'b1;
        is_mod  = 1'b1;
      end
      default: begin
        kind_ok = 1'b0;
        is_mod  = 1'b0;
      end
    endcase

    // A modify stamps the line twice; only the second stamp remains.
    line_stamp = stamp_r + STAMP_W'(is_mod);
    stamp_nxt  = line_stamp + STAMP_W'(1);

    hits_add = 2'(hit) + 2'(is_mod);
    missed   = !hit;
    evicted  = !hit && full;
    if (!kind_ok) begin
      hits_add = 2'd0;
      missed   = 1'b0;
      evicted  = 1'b0;
    end

    wr_row                = rd_row_r;
    wr_row.valid          = row_v;
    wr_row.valid[sel_way] = 1'b1;
    wr_row.tag[sel_way]   = tag_r;
    wr_row.stamp[sel_way] = line_stamp;

    wr_en = cmd.commit && kind_ok;
  end

  // Memory and payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_row_r <= mem[set_idx];
      kind_r   <= in_data.kind;
      tag_r    <= tag_c;
      set_r    <= set_idx;
    end
    if (wr_en) begin
      mem[set_r] <= wr_row;
    end
    if (cmd.commit) begin
      out_data_r.hits_added     <= hits_add;
      out_data_r.missed         <= missed;
      out_data_r.evicted        <= evicted;
      out_data_r.hit_total      <= hits_r + CNT_W'(hits_add);
      out_data_r.miss_total     <= misses_r + CNT_W'(missed);
      out_data_r.eviction_total <= evicts_r + CNT_W'(evicted);
    end
  end

  // Control state: row flags, stamp and running totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_init_r  <= '0;
      row_ok_r    <= 1'b0;
      stamp_r     <= STAMP_W'(1);
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
      if (cmd.capture) begin
        row_ok_r <= row_init_r[set_idx];
      end
      if (wr_en) begin
        row_init_r[set_r] <= 1'b1;
        stamp_r           <= stamp_nxt;
        hits_r            <= hits_r + CNT_W'(hits_add);
        misses_r          <= misses_r + CNT_W'(missed);
        evicts_r          <= evicts_r + CNT_W'(evicted);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/set_assoc_lru_cache_model.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Tag store of a set-associative cache with LRU replacement and hit, miss and
// eviction counters.
//
//   Channel  Ports                          Transfer
//   input    start, busy, in_data           start high while busy low
//   result   out_valid, out_data            out_valid high for one cycle
//   config   cfg_we, cfg_index, cfg_wdata   cfg_we high, no wait
//
// For each item, the accepting edge reads the set's row from the single-port row
// memory, and the next edge compares, picks the way and writes the row back.
// The result is strobed in the cycle after that, while the next item may
// already be accepted. Reset clears one flag per set instead of sweeping the
// memory, so the block is ready straight after reset. The receiver cannot
// stall results.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model
  import slc_pkg::*;
#(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t     cfg_r;
  ctl_cmd_t cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_bits    <= SET_BITS_RST;
      cfg_r.block_bits  <= BLOCK_BITS_RST;
      cfg_r.ways_in_use <= WAYS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SET_BITS:   cfg_r.set_bits    <= cfg_wdata[2:0];
        CFG_BLOCK_BITS: cfg_r.block_bits  <= cfg_wdata[4:0];
        CFG_WAYS:       cfg_r.ways_in_use <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  slc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  slc_datapath #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted item");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("result not strobed two cycles after an accepted item");

  a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.evicted) |-> out_data.missed)
    else $error("eviction reported without a miss");

  a_miss_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.missed) |-> (out_data.hits_added != 2'd2))
    else $error("a missing item reported two hits");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the set-associative LRU cache tag store. A directed
// walk through the reset geometry is followed by random accesses under a run
// of cache geometries, each result checked against a table or an LRU tag model.
// ----------------------------------------------------------------------------
module tb;
  import slc_pkg::*;

  localparam logic [1:0] KIND_IGNORED = 2'd3;
  localparam int         PHASES       = 10;
  localparam int         PHASE_ITEMS  = 140;
  localparam int         STORE_LINES  = (1 << MAX_SET_BITS_DEF) * MAX_WAYS_DEF;

  typedef struct packed {
    in_item_t  acc;
    logic      known;
    out_item_t res;
  } dir_row_t;

  // Reset geometry: 16 sets, 16-byte blocks, one way.
  localparam dir_row_t DIRECTED [15] = '{
    '{'{KIND_LOAD,    64'h0},                  1'b1, '{2'd0, 1'b1, 1'b0, 32'd0, 32'd1, 32'd0}},
    '{'{KIND_LOAD,    64'h8},                  1'b1, '{2'd1, 1'b0, 1'b0, 32'd1, 32'd1, 32'd0}},
    '{'{KIND_STORE,   64'h0},                  1'b1, '{2'd1, 1'b0, 1'b0, 32'd2, 32'd1, 32'd0}},
    '{'{KIND_MODIFY,  64'h100},                1'b1, '{2'd1, 1'b1, 1'b1, 32'd3, 32'd2, 32'd1}},
    '{'{KIND_IGNORED, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, '{2'd0, 1'b0, 1'b0, 32'd3, 32'd2, 32'd1}},
    '{'{KIND_LOAD,    64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, '{2'd0, 1'b1, 1'b0, 32'd3, 32'd3, 32'd1}},
    '{'{KIND_MODIFY,  64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, '{2'd2, 1'b0, 1'b0, 32'd5, 32'd3, 32'd1}},
    '{'{KIND_STORE,   64'h10},                 1'b1, '{2'd0, 1'b1, 1'b0, 32'd5, 32'd4, 32'd1}},
    '{'{KIND_STORE,   64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, '0},
    '{'{KIND_LOAD,    64'h5555_5555_5555_5555}, 1'b0, '0},
    '{'{KIND_MODIFY,  64'h8000_0000_0000_0000}, 1'b0, '0},
    '{'{KIND_LOAD,    64'h8000_0000_0000_000F}, 1'b0, '0},
    '{'{KIND_IGNORED, 64'h0},                  1'b0, '0},
    '{'{KIND_STORE,   64'hFFFF_FFFF_FFFF_FFF0}, 1'b0, '0},
    '{'{KIND_MODIFY,  64'h0000_0000_0000_0010}, 1'b0, '0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_data;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Tag store mirror and counters.
  logic        line_ok  [STORE_LINES];
  logic [63:0] line_tag [STORE_LINES];
  logic [63:0] line_age [STORE_LINES];
  logic [63:0] stamp_next;
  logic [31:0] hit_cnt;
  logic [31:0] miss_cnt;
  logic [31:0] evict_cnt;
  logic [2:0]  cfg_sets;
  logic [4:0]  cfg_block;
  logic [3:0]  cfg_ways;
  int          eff_set_bits;
  int          eff_ways;

  out_item_t   pending_results [$];
  int          mismatch_count;
  int          items_sent;
  int          results_checked;
  bit          no_gaps;

  set_assoc_lru_cache_model u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // A store looks up exactly as a load does, and a modify is two lookups of
  // which the second always hits.
  function automatic out_item_t predict_access(in_item_t acc);
    out_item_t   r;
    int          passes, base, w, hit_way, empty, victim;
    logic [63:0] tag, oldest;
    bit          full;
    r       = '0;
    tag     = acc.address >> (eff_set_bits + cfg_block);
    base    = int'((acc.address >> cfg_block) & ((64'd1 << eff_set_bits) - 64'd1)) *
              MAX_WAYS_DEF;
    passes  = (acc.kind == KIND_MODIFY) ? 2 :
              (acc.kind == KIND_LOAD || acc.kind == KIND_STORE) ? 1 : 0;
    for (int p = 0; p < passes; p++) begin
      hit_way = eff_ways;
      for (w = 0; w < eff_ways; w++)
        if (hit_way == eff_ways && line_ok[base + w] && line_tag[base + w] == tag)
          hit_way = w;
      if (hit_way < eff_ways) begin
        line_age[base + hit_way] = stamp_next;
        stamp_next++;
        hit_cnt++;
        r.hits_added++;
      end else begin
        oldest = line_age[base];
        victim = 0;
        empty  = 0;
        full   = 1'b1;
        for (w = 0; w < eff_ways; w++) begin
          if (!line_ok[base + w]) begin
            full  = 1'b0;
            empty = w;
          end
          if (line_age[base + w] < oldest) begin
            oldest = line_age[base + w];
            victim = w;
          end
        end
        if (!full)
          victim = empty;
        line_ok[base + victim]  = 1'b1;
        line_tag[base + victim] = tag;
        line_age[base + victim] = stamp_next;
        stamp_next++;
        miss_cnt++;
        r.missed = 1'b1;
        if (full) begin
          evict_cnt++;
          r.evicted = 1'b1;
        end
      end
    end
    r.hit_total      = hit_cnt;
    r.miss_total     = miss_cnt;
    r.eviction_total = evict_cnt;
    return r;
  endfunction

  // Returns at the edge that accepts the item.
  task automatic send_access(in_item_t acc);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= acc;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, got %h", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        check_field("hits_added",     want.hits_added,     out_data.hits_added);
        check_field("missed",         want.missed,         out_data.missed);
        check_field("evicted",        want.evicted,        out_data.evicted);
        check_field("hit_total",      want.hit_total,      out_data.hit_total);
        check_field("miss_total",     want.miss_total,     out_data.miss_total);
        check_field("eviction_total", want.eviction_total, out_data.eviction_total);
      end
    end
  end

  initial begin : stimulus
    int          phase, n, k;
    logic [2:0]  sb_w;
    logic [4:0]  bb_w;
    logic [3:0]  ways_w;
    logic [63:0] tag_base, t, s, off;
    in_item_t    acc;
    out_item_t   want;

    for (n = 0; n < STORE_LINES; n++) begin
      line_ok[n]  = 1'b0;
      line_tag[n] = '0;
      line_age[n] = '0;
    end
    stamp_next      = 64'd1;
    hit_cnt         = '0;
    miss_cnt        = '0;
    evict_cnt       = '0;
    cfg_sets        = SET_BITS_RST;
    cfg_block       = BLOCK_BITS_RST;
    cfg_ways        = WAYS_RST;
    eff_set_bits    = SET_BITS_RST;
    eff_ways        = WAYS_RST;
    mismatch_count  = 0;
    items_sent      = 0;
    results_checked = 0;
    no_gaps         = 1'b0;

    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_SET_BITS;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < $size(DIRECTED); n++) begin
      send_access(DIRECTED[n].acc);
      want = predict_access(DIRECTED[n].acc);
      pending_results.push_back(DIRECTED[n].known ? DIRECTED[n].res : want);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      // Geometry changes only once the block has drained.
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);

      case (phase)
        0: begin sb_w = 3'd0; bb_w = 5'd0;  ways_w = 4'd0;  end
        1: begin sb_w = 3'd7; bb_w = 5'd31; ways_w = 4'd15; end
        2: begin sb_w = 3'd6; bb_w = 5'd16; ways_w = 4'd8;  end
        3: begin sb_w = 3'd6; bb_w = 5'd0;  ways_w = 4'd8;  end
        4: begin sb_w = 3'd0; bb_w = 5'd31; ways_w = 4'd1;  end
        default: begin
          sb_w   = 3'($urandom_range(0, 7));
          bb_w   = 5'($urandom_range(0, 31));
          ways_w = 4'($urandom_range(0, 15));
        end
      endcase

      cfg_we    <= 1'b1;
      cfg_index <= CFG_SET_BITS;
      cfg_wdata <= CFG_DATA_W'(sb_w);
      @(posedge clk);
      cfg_index <= CFG_BLOCK_BITS;
      cfg_wdata <= CFG_DATA_W'(bb_w);
      @(posedge clk);
      cfg_index <= CFG_WAYS;
      cfg_wdata <= CFG_DATA_W'(ways_w);
      @(posedge clk);
      cfg_we       <= 1'b0;
      cfg_sets     = sb_w;
      cfg_block    = bb_w;
      cfg_ways     = ways_w;
      eff_set_bits = (cfg_sets > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : cfg_sets;
      eff_ways     = (cfg_ways == 0) ? 1 :
                     (cfg_ways > MAX_WAYS_DEF) ? MAX_WAYS_DEF : cfg_ways;

      no_gaps  = ($urandom_range(0, 3) == 0);
      tag_base = $urandom_range(0, 1) ? 64'd0 :
                 ({$urandom, $urandom} >> (eff_set_bits + cfg_block));

      for (n = 0; n < PHASE_ITEMS; n++) begin
        k        = $urandom_range(0, 19);
        acc.kind = (k == 0) ? KIND_IGNORED : (k < 8) ? KIND_LOAD :
                   (k < 14) ? KIND_STORE : KIND_MODIFY;
        if ($urandom_range(0, 9) == 0) begin
          acc.address = {$urandom, $urandom};
        end else begin
          // A handful of tags over a few sets, so that lines are reused,
          // sets fill up and the oldest line gets evicted.
          t   = tag_base + 64'($urandom_range(0, eff_ways + 1));
          s   = 64'($urandom_range(0, 3)) & ((64'd1 << eff_set_bits) - 64'd1);
          off = {$urandom, $urandom} & ((64'd1 << cfg_block) - 64'd1);
          acc.address = (t << (eff_set_bits + cfg_block)) | (s << cfg_block) | off;
        end
        send_access(acc);
        pending_results.push_back(predict_access(acc));
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d results for %0d accesses over %0d cache geometries.",
             results_checked, items_sent, PHASES + 1);
    $display("Totals seen: %0d hits, %0d misses, %0d evictions.",
             hit_cnt, miss_cnt, evict_cnt);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/slc_pkg.sv
rtl/slc_ctrl.sv
rtl/slc_datapath.sv
rtl/set_assoc_lru_cache_model.sv
verif/tb.sv
